FILE: rtl/wpm_pkg.sv
package wpm_pkg;

  localparam int LEN_BITS  = 9;
  localparam int FRAC_BITS = 8;
  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd240;

  typedef logic [ADDR_BITS-3:0] reg_idx_t;
  localparam reg_idx_t REG_WINDOW_LENGTH = 1'b0;

  // head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic positive;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_DIVIDE = 3'b100
  } back_state_t;

endpackage

FILE: rtl/windowed_positive_mean.sv
// channel   direction  signals
// sample    in         sample_valid, sample_ready, sample
// result    out        result_valid, result_ready, mean_value, positive_count
// config    in         psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// each sample in turn: ring read, update, the serial divider at one quotient bit
// per cycle, result load
// a two-entry request queue keeps taking samples while the back end works
// reset and any window_length write empty the window at once, no sweep
// a result not taken holds the back end, the queue then fills and stalls input
module windowed_positive_mean #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      sample_valid,
  output logic                                      sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]             sample,
  output logic                                      result_valid,
  input  logic                                      result_ready,
  output logic [SAMPLE_BITS+wpm_pkg::FRAC_BITS-2:0] mean_value,
  output logic [$clog2(MAX_WINDOW+1)-1:0]           positive_count,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [wpm_pkg::ADDR_BITS-1:0]             paddr,
  input  logic [wpm_pkg::DATA_BITS-1:0]             pwdata,
  output logic [wpm_pkg::DATA_BITS-1:0]             prdata,
  output logic                                      pready
);
  import wpm_pkg::*;

  logic [LEN_BITS-1:0]    window_length;
  logic                   sel_len;
  logic                   clear;
  q_head_t                head;
  logic [SAMPLE_BITS-1:0] head_sample;
  logic                   pop;

  assign pready  = 1'b1;
  assign sel_len = (paddr[ADDR_BITS-1:2] == REG_WINDOW_LENGTH);
  assign clear   = psel && penable && pwrite && pready && sel_len;
  assign prdata  = sel_len ? DATA_BITS'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (clear) begin
      window_length <= pwdata[LEN_BITS-1:0];
    end
  end

  wpm_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .head        (head),
    .head_sample (head_sample),
    .pop         (pop)
  );

  wpm_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .clear         (clear),
    .window_length (window_length),
    .head          (head),
    .head_sample   (head_sample),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .mean_value    (mean_value),
    .positive_count(positive_count)
  );

  a_zero_mean: assert property (@(posedge clk) disable iff (rst)
    result_valid && (positive_count == '0) |-> (mean_value == '0))
    else $error("mean not zero with empty count");

  a_mean_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid && (positive_count != '0) |-> (mean_value >= (1 << FRAC_BITS)))
    else $error("mean below one with positive samples");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (positive_count <= MAX_WINDOW))
    else $error("count beyond window");

endmodule

FILE: rtl/wpm_front.sv
module wpm_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic [SAMPLE_BITS-1:0]   sample,
  output wpm_pkg::q_head_t         head,
  output logic [SAMPLE_BITS-1:0]   head_sample,
  input  logic                     pop
);
  import wpm_pkg::*;

  logic [SAMPLE_BITS-1:0] q_sample [2];
  logic                   q_pos    [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;
  logic                   push;
  logic                   positive;

  // strictly positive: nonzero with sign bit clear
  assign positive     = (sample != '0) && !sample[SAMPLE_BITS-1];
  assign sample_ready = (fill != 2'd2);
  assign push         = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_sample[wr_ptr] <= sample;
      q_pos[wr_ptr]    <= positive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign head.valid    = (fill != 2'd0);
  assign head.positive = q_pos[rd_ptr];
  assign head_sample   = q_sample[rd_ptr];

endmodule

FILE: rtl/wpm_div.sv
module wpm_div #(
  parameter int DIVIDEND_BITS = 32,
  parameter int DIVISOR_BITS  = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     busy,
  output logic [DIVIDEND_BITS-1:0] quotient
);
  import wpm_pkg::*;

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] dq;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [STEP_BITS-1:0]     steps;
  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, dq[DIVIDEND_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[DIVIDEND_BITS-2:0], ge};
      rem <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_BITS'(DIVIDEND_BITS);
    end else if (busy) begin
      steps <= steps - STEP_BITS'(1);
    end
  end

  assign busy     = (steps != '0);
  assign quotient = dq;

endmodule

FILE: rtl/wpm_back.sv
module wpm_back #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      clear,
  input  logic [wpm_pkg::LEN_BITS-1:0]              window_length,
  input  wpm_pkg::q_head_t                          head,
  input  logic [SAMPLE_BITS-1:0]                    head_sample,
  output logic                                      pop,
  output logic                                      result_valid,
  input  logic                                      result_ready,
  output logic [SAMPLE_BITS+wpm_pkg::FRAC_BITS-2:0] mean_value,
  output logic [$clog2(MAX_WINDOW+1)-1:0]           positive_count
);
  import wpm_pkg::*;

  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CNTW  = $clog2(MAX_WINDOW + 1);
  localparam int SUMW  = SAMPLE_BITS - 1 + CNTW;
  localparam int MEANW = SAMPLE_BITS + FRAC_BITS - 1;
  localparam int DW    = SUMW + FRAC_BITS;
  localparam int EW    = (LEN_BITS > CNTW) ? LEN_BITS : CNTW;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rdata;

  back_state_t            state;
  logic [AW-1:0]          wpos;
  logic                   wrapped;
  logic [SUMW-1:0]        psum;
  logic [CNTW-1:0]        ptotal;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic                   cur_pos;

  logic [AW-1:0]          last_pos;
  logic [EW-1:0]          len_ext;
  logic [SAMPLE_BITS-1:0] outgoing;
  logic                   out_pos;
  logic [SUMW-1:0]        psum_next;
  logic [CNTW-1:0]        ptotal_next;
  logic                   div_start;
  logic                   div_busy;
  logic [DW-1:0]          quotient;
  logic                   load;

  // length zero acts as one, lengths past the ring saturate
  assign len_ext = EW'(window_length);
  always_comb begin
    priority if (len_ext == '0) begin
      last_pos = '0;
    end else if (len_ext >= EW'(MAX_WINDOW)) begin
      last_pos = AW'(MAX_WINDOW - 1);
    end else begin
      last_pos = AW'(len_ext - EW'(1));
    end
  end

  assign pop = head.valid && (state == ST_IDLE);

  // slots not yet written since the last clear read as zero
  assign outgoing = wrapped ? rdata : '0;
  assign out_pos  = (outgoing != '0) && !outgoing[SAMPLE_BITS-1];

  always_comb begin
    psum_next   = psum;
    ptotal_next = ptotal;
    if (out_pos) begin
      psum_next   = psum_next - SUMW'(outgoing[SAMPLE_BITS-2:0]);
      ptotal_next = ptotal_next - CNTW'(1);
    end
    if (cur_pos) begin
      psum_next   = psum_next + SUMW'(cur_sample[SAMPLE_BITS-2:0]);
      ptotal_next = ptotal_next + CNTW'(1);
    end
  end

  assign div_start = (state == ST_UPDATE);
  assign load      = (state == ST_DIVIDE) && !div_busy && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= ring[wpos];
    end
    if (state == ST_UPDATE) begin
      ring[wpos] <= cur_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_sample <= head_sample;
      cur_pos    <= head.positive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wpos    <= '0;
      wrapped <= 1'b0;
      psum    <= '0;
      ptotal  <= '0;
    end else if (clear) begin
      wpos    <= '0;
      wrapped <= 1'b0;
      psum    <= '0;
      ptotal  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          psum   <= psum_next;
          ptotal <= ptotal_next;
          if (wpos == last_pos) begin
            wpos    <= '0;
            wrapped <= 1'b1;
          end else begin
            wpos <= wpos + AW'(1);
          end
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  wpm_div #(
    .DIVIDEND_BITS(DW),
    .DIVISOR_BITS (CNTW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend({psum_next, FRAC_BITS'(0)}),
    .divisor (ptotal_next),
    .busy    (div_busy),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mean_value     <= (ptotal == '0) ? '0 : quotient[MEANW-1:0];
      positive_count <= ptotal;
    end
  end

endmodule
